@@ src/gha_pkg.sv @@
// Shared types and constants of the generational handle allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package gha_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = IDX_W + 1;
	localparam int GEN_W      = 32;

	localparam logic [GEN_W-1:0] FIRST_GEN = GEN_W'(1);
	localparam logic [GEN_W-1:0] LAST_GEN  = {GEN_W{1'b1}};

	typedef enum logic [1:0] {
		FUNC_CREATE    = 2'd0,
		FUNC_DESTROY   = 2'd1,
		FUNC_QUERY     = 2'd2,
		FUNC_HANDLE_AT = 2'd3
	} func_t;

	localparam logic [1:0] ST_UNUSED  = 2'd0;
	localparam logic [1:0] ST_ALIVE   = 2'd1;
	localparam logic [1:0] ST_RETIRED = 2'd2;

	typedef struct packed {
		logic [1:0]       func;
		logic [IDX_W-1:0] entity_index;
		logic [GEN_W-1:0] entity_generation;
	} in_item_t;

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] handle_index;
		logic [GEN_W-1:0] handle_generation;
		logic [CNT_W-1:0] alive_count;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       state;
		logic [GEN_W-1:0] gen;
	} slot_word_t;

	typedef struct packed {
		logic accept;
		logic stk_re;
		logic slot_re;
		logic slot_from_stack;
		logic fire;
	} gha_cmd_t;

	typedef struct packed {
		logic go_pop;
		logic go_read;
		logic out_free;
	} gha_sts_t;

endpackage

@@ src/gha_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/gha_ctrl.sv @@
// Sequencer of the handle allocator: steps each transaction through its
// memory reads. Depends on gha_pkg.
module gha_ctrl
	import gha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  gha_sts_t sts,
	output gha_cmd_t cmd,
	output logic     in_stall
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_POP  = 5'b00010,
		S_POPD = 5'b00100,
		S_READ = 5'b01000,
		S_EVAL = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					if (sts.go_pop) begin
						state_d = S_POP;
					end else if (sts.go_read) begin
						state_d = S_READ;
					end else begin
						state_d = S_EVAL;
					end
				end
			end
			S_POP: begin
				cmd.stk_re = 1'b1;
				state_d = S_POPD;
			end
			S_POPD: begin
				cmd.slot_re = 1'b1;
				cmd.slot_from_stack = 1'b1;
				state_d = S_EVAL;
			end
			S_READ: begin
				cmd.slot_re = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.fire = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

@@ src/gha_dp.sv @@
// Datapath of the handle allocator: slot and free-stack memories, counters
// and the result register. Depends on gha_pkg and gha_ram.
module gha_dp
	import gha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  gha_cmd_t  cmd,
	input  in_item_t  in_data,
	input  logic      out_stall,
	output gha_sts_t  sts,
	output logic      out_valid,
	output out_item_t out_data
);

	logic [1:0]       func_q;
	logic [IDX_W-1:0] idx_q;
	logic [GEN_W-1:0] gen_q;
	logic             from_stack_q;
	logic             in_range_q;
	logic [IDX_W-1:0] slot_q;
	logic [CNT_W-1:0] depth_q;
	logic [CNT_W-1:0] fresh_q;
	logic [CNT_W-1:0] live_q;
	logic             out_valid_q;
	out_item_t        out_q;

	slot_word_t       slot_rd;
	slot_word_t       slot_wd;
	logic [$bits(slot_word_t)-1:0] slot_rdata;
	logic [IDX_W-1:0] slot_raddr;
	logic [IDX_W-1:0] slot_waddr;
	logic             slot_we;
	logic [IDX_W-1:0] stk_rdata;
	logic             push;
	logic             pop;
	logic             fresh_inc;
	logic             live_inc;
	logic             live_dec;
	logic             ok_c;
	logic [GEN_W-1:0] r_gen;
	logic [IDX_W-1:0] r_idx;
	logic             alive_hit;
	logic [CNT_W-1:0] live_next;

	assign sts.go_pop   = (in_data.func == FUNC_CREATE) && (depth_q != '0);
	assign sts.go_read  = (in_data.func != FUNC_CREATE) &&
	                      ({1'b0, in_data.entity_index} < fresh_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign slot_rd    = slot_word_t'(slot_rdata);
	assign slot_raddr = cmd.slot_from_stack ? stk_rdata : idx_q;
	assign alive_hit  = in_range_q && (gen_q != '0) && (slot_rd.state == ST_ALIVE) &&
	                    (slot_rd.gen == gen_q);

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wd    = slot_rd;
		push       = 1'b0;
		pop        = 1'b0;
		fresh_inc  = 1'b0;
		live_inc   = 1'b0;
		live_dec   = 1'b0;
		ok_c       = 1'b0;
		r_idx      = '0;
		r_gen      = '0;
		case (func_q)
			FUNC_CREATE: begin
				if (from_stack_q) begin
					pop = 1'b1;
					if (slot_rd.state != ST_RETIRED) begin
						slot_we       = 1'b1;
						slot_waddr    = slot_q;
						slot_wd.state = ST_ALIVE;
						ok_c          = 1'b1;
						r_idx         = slot_q;
						r_gen         = slot_rd.gen;
					end
				end else if (fresh_q < CNT_W'(SLOT_COUNT)) begin
					slot_we       = 1'b1;
					slot_waddr    = fresh_q[IDX_W-1:0];
					slot_wd.state = ST_ALIVE;
					slot_wd.gen   = FIRST_GEN;
					fresh_inc     = 1'b1;
					ok_c          = 1'b1;
					r_idx         = fresh_q[IDX_W-1:0];
					r_gen         = FIRST_GEN;
				end
				live_inc = ok_c;
			end
			FUNC_DESTROY: begin
				if (alive_hit) begin
					ok_c     = 1'b1;
					r_idx    = idx_q;
					r_gen    = gen_q;
					live_dec = (live_q != '0);
					slot_we  = 1'b1;
					if (slot_rd.gen == LAST_GEN) begin
						slot_wd.state = ST_RETIRED;
					end else begin
						slot_wd.state = ST_UNUSED;
						slot_wd.gen   = slot_rd.gen + FIRST_GEN;
						push          = (depth_q < CNT_W'(SLOT_COUNT));
					end
				end
			end
			FUNC_QUERY: begin
				if (alive_hit) begin
					ok_c  = 1'b1;
					r_idx = idx_q;
					r_gen = gen_q;
				end
			end
			default: begin
				if (in_range_q && (slot_rd.state == ST_ALIVE)) begin
					ok_c  = 1'b1;
					r_idx = idx_q;
					r_gen = slot_rd.gen;
				end
			end
		endcase
	end

	always_comb begin
		live_next = live_q;
		if (live_inc) begin
			live_next = live_q + CNT_W'(1);
		end else if (live_dec) begin
			live_next = live_q - CNT_W'(1);
		end
	end

	gha_ram #(
		.WIDTH($bits(slot_word_t)),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (cmd.fire && slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wd),
		.re   (cmd.slot_re),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	gha_ram #(
		.WIDTH(IDX_W),
		.DEPTH(SLOT_COUNT)
	) u_stack_ram (
		.clk  (clk),
		.we   (cmd.fire && push),
		.waddr(depth_q[IDX_W-1:0]),
		.wdata(idx_q),
		.re   (cmd.stk_re),
		.raddr(IDX_W'(depth_q - CNT_W'(1))),
		.rdata(stk_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q       <= in_data.func;
			idx_q        <= in_data.entity_index;
			gen_q        <= in_data.entity_generation;
			from_stack_q <= (depth_q != '0);
			in_range_q   <= ({1'b0, in_data.entity_index} < fresh_q);
		end
		if (cmd.slot_from_stack) begin
			slot_q <= stk_rdata;
		end
		if (cmd.fire) begin
			out_q.ok                <= ok_c;
			out_q.handle_index      <= r_idx;
			out_q.handle_generation <= r_gen;
			out_q.alive_count       <= live_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			fresh_q     <= '0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fire) begin
				live_q <= live_next;
				if (fresh_inc) begin
					fresh_q <= fresh_q + CNT_W'(1);
				end
				if (pop) begin
					depth_q <= depth_q - CNT_W'(1);
				end else if (push) begin
					depth_q <= depth_q + CNT_W'(1);
				end
			end
			if (cmd.fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_live_le_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= fresh_q)
		else $error("alive count exceeds slots handed out");

	a_depth_live_le_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, depth_q} + {1'b0, live_q}) <= {1'b0, fresh_q})
		else $error("free and alive slots exceed slots handed out");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.ok |-> (out_q.handle_index == '0) &&
		                              (out_q.handle_generation == '0))
		else $error("failed transaction carries a handle");

	a_destroy_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire && (func_q == FUNC_DESTROY) && ok_c |=>
		live_q == $past(live_q) - CNT_W'(1))
		else $error("destroy did not lower the alive count");

endmodule

@@ src/generational_handle_allocator.sv @@
// Top level of the generational handle allocator: joins the sequencer and
// the datapath. Depends on gha_pkg, gha_ctrl, gha_dp (and gha_ram below it).
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one operation per
//   transaction: create, destroy, alive query or handle at index. Output
//   channel out_valid / out_stall / out_data returns exactly one result per
//   operation, in order: ok, handle index, handle generation, alive count.
//   An operation that needs no memory read (create of a fresh slot, full,
//   index out of range) goes from acceptance straight to evaluation;
//   operations that read the slot memory do a slot read first, and a create
//   that pops the free stack does a stack read, then a slot read. The result
//   is registered. One operation is in work at a time: no new transaction is
//   accepted until the last one has been written to the output register.
//   Reset clears the counters, out_valid and the sequencer only; no memory
//   sweep runs and the block takes its first transaction right after reset.
//   A stalled result holds in the output register; the next operation is
//   accepted and completes its reads, then waits until the output is free.
module generational_handle_allocator
	import gha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	gha_cmd_t cmd;
	gha_sts_t sts;

	gha_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.sts     (sts),
		.cmd     (cmd),
		.in_stall(in_stall)
	);

	gha_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_stall(out_stall),
		.sts      (sts),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

@@ bench/generational_handle_allocator_tb.sv @@
// Self-checking bench for generational_handle_allocator: directed and random operations.
// An inline allocator predictor and a result queue check every output transaction.
// Depends on gha_pkg and the generational_handle_allocator RTL only.
`timescale 1ns / 100ps

module generational_handle_allocator_tb;
	import gha_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_CAP   = 40;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	generational_handle_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #4 clk = ~clk;

	logic [GEN_W-1:0] slot_gen     [SLOT_COUNT];
	logic [1:0]       slot_state   [SLOT_COUNT];
	logic [IDX_W-1:0] recycle_stack[SLOT_COUNT];
	logic [CNT_W-1:0] recycle_depth = '0;
	logic [CNT_W-1:0] fresh_count   = '0;
	logic [CNT_W-1:0] live_count    = '0;

	in_item_t  op_queue[$];
	out_item_t awaited_results[$];
	int        queued_count   = 0;
	int        accepted_count = 0;
	int        mismatch_count = 0;
	int        cycle_count    = 0;

	function automatic logic handle_is_alive(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
		if (gen == '0 || idx >= fresh_count)
			return 1'b0;
		return slot_state[idx] == ST_ALIVE && slot_gen[idx] == gen;
	endfunction

	function automatic out_item_t apply_operation(in_item_t item);
		out_item_t        res;
		logic [IDX_W-1:0] slot;
		logic             got;
		res  = '0;
		slot = '0;
		got  = 1'b0;
		case (func_t'(item.func))
		FUNC_CREATE: begin
			if (recycle_depth != '0) begin
				recycle_depth = recycle_depth - 1'b1;
				slot = recycle_stack[recycle_depth];
				got  = 1'b1;
			end else if (fresh_count < SLOT_COUNT) begin
				slot = fresh_count[IDX_W-1:0];
				fresh_count = fresh_count + 1'b1;
				slot_gen[slot]   = FIRST_GEN;
				slot_state[slot] = ST_UNUSED;
				got = 1'b1;
			end
			if (got && slot_state[slot] != ST_RETIRED) begin
				slot_state[slot] = ST_ALIVE;
				live_count = live_count + 1'b1;
				res.ok                = 1'b1;
				res.handle_index      = slot;
				res.handle_generation = slot_gen[slot];
			end
		end
		FUNC_DESTROY: begin
			if (handle_is_alive(item.entity_index, item.entity_generation)) begin
				res.ok                = 1'b1;
				res.handle_index      = item.entity_index;
				res.handle_generation = item.entity_generation;
				if (live_count != '0)
					live_count = live_count - 1'b1;
				if (slot_gen[item.entity_index] == LAST_GEN) begin
					slot_state[item.entity_index] = ST_RETIRED;
				end else begin
					slot_state[item.entity_index] = ST_UNUSED;
					slot_gen[item.entity_index]   = slot_gen[item.entity_index] + 1'b1;
					if (recycle_depth < SLOT_COUNT) begin
						recycle_stack[recycle_depth] = item.entity_index;
						recycle_depth = recycle_depth + 1'b1;
					end
				end
			end
		end
		FUNC_QUERY: begin
			if (handle_is_alive(item.entity_index, item.entity_generation)) begin
				res.ok                = 1'b1;
				res.handle_index      = item.entity_index;
				res.handle_generation = item.entity_generation;
			end
		end
		default: begin
			if (item.entity_index < fresh_count && slot_state[item.entity_index] == ST_ALIVE) begin
				res.ok                = 1'b1;
				res.handle_index      = item.entity_index;
				res.handle_generation = slot_gen[item.entity_index];
			end
		end
		endcase
		res.alive_count = live_count;
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// driver: bursts of transactions separated by random gaps
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				awaited_results.push_back(apply_operation(in_data));
				accepted_count++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (op_queue.size() != 0) begin
					in_data  <= op_queue.pop_front();
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(40, 1);
						gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check results, stall on its own pattern
	int   stall_mode = 0;
	int   mode_left  = 0;
	int   run_left   = 0;
	logic run_level  = 1'b0;

	always @(posedge clk) begin : monitor
		out_item_t want;
		logic      stall_next;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %p", out_data));
				end else begin
					want = awaited_results.pop_front();
					if (out_data.ok !== want.ok)
						report_mismatch($sformatf("ok %b, want %b", out_data.ok, want.ok));
					if (out_data.handle_index !== want.handle_index)
						report_mismatch($sformatf("handle_index %0d, want %0d",
							out_data.handle_index, want.handle_index));
					if (out_data.handle_generation !== want.handle_generation)
						report_mismatch($sformatf("handle_generation %0h, want %0h",
							out_data.handle_generation, want.handle_generation));
					if (out_data.alive_count !== want.alive_count)
						report_mismatch($sformatf("alive_count %0d, want %0d",
							out_data.alive_count, want.alive_count));
				end
			end
			if (mode_left == 0) begin
				mode_left  = $urandom_range(200, 20);
				stall_mode = $urandom_range(2);
			end
			mode_left--;
			case (stall_mode)
			0: stall_next = 1'b0;
			1: stall_next = ($urandom_range(2) == 0);
			default: begin
				if (run_left == 0) begin
					run_level = ~run_level;
					run_left  = run_level ? $urandom_range(12, 1) : $urandom_range(6, 1);
				end
				run_left--;
				stall_next = run_level;
			end
			endcase
			out_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic in_item_t make_op(func_t f, int idx, logic [GEN_W-1:0] gen);
		in_item_t item;
		item.func              = f;
		item.entity_index      = IDX_W'(idx);
		item.entity_generation = gen;
		return item;
	endfunction

	function automatic int pick_alive_slot();
		int idx;
		if (fresh_count == '0)
			return -1;
		for (int i = 0; i < 8; i++) begin
			idx = $urandom_range(int'(fresh_count) - 1);
			if (slot_state[idx] == ST_ALIVE)
				return idx;
		end
		return -1;
	endfunction

	function automatic logic [GEN_W-1:0] near_generation(int idx);
		if (idx >= int'(fresh_count))
			return $urandom;
		case ($urandom_range(3))
		0: return slot_gen[idx] - 1'b1;
		1: return slot_gen[idx] + 1'b1;
		2: return '0;
		default: return $urandom;
		endcase
	endfunction

	function automatic int any_seen_slot();
		if (fresh_count == '0 || $urandom_range(3) == 0)
			return $urandom_range(SLOT_COUNT - 1);
		return $urandom_range(int'(fresh_count) - 1);
	endfunction

	function automatic in_item_t random_op(int create_pct);
		int alive_idx;
		int idx;
		int pick;
		alive_idx = pick_alive_slot();
		idx       = any_seen_slot();
		pick      = $urandom_range(99);
		if ($urandom_range(99) < create_pct)
			return make_op(FUNC_CREATE, $urandom_range(SLOT_COUNT - 1), $urandom);
		if (pick < 35 && alive_idx >= 0)
			return make_op(FUNC_DESTROY, alive_idx, slot_gen[alive_idx]);
		if (pick < 45)
			return make_op(FUNC_DESTROY, idx, near_generation(idx));
		if (pick < 65 && alive_idx >= 0)
			return make_op(FUNC_QUERY, alive_idx, slot_gen[alive_idx]);
		if (pick < 75)
			return make_op(FUNC_QUERY, idx, near_generation(idx));
		if (pick < 90)
			return make_op(FUNC_HANDLE_AT, idx, $urandom);
		return make_op(func_t'($urandom_range(3)), $urandom_range(SLOT_COUNT - 1), $urandom);
	endfunction

	task automatic push_op(in_item_t item);
		op_queue.push_back(item);
		queued_count++;
	endtask

	task automatic wait_accepted();
		while (accepted_count != queued_count)
			@(negedge clk);
	endtask

	// issue in chunks so that handles are picked from up-to-date allocator state
	task automatic issue_random(int count, int create_pct, bit until_full);
		int issued;
		int chunk;
		issued = 0;
		while (issued < count && !(until_full && live_count == SLOT_COUNT)) begin
			chunk = $urandom_range(32, 1);
			for (int i = 0; i < chunk && issued < count; i++) begin
				push_op(random_op(create_pct));
				issued++;
			end
			wait_accepted();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_op(make_op(FUNC_CREATE, 0, '0));
		push_op(make_op(FUNC_CREATE, SLOT_COUNT - 1, LAST_GEN));
		push_op(make_op(FUNC_CREATE, 0, '0));
		push_op(make_op(FUNC_QUERY, 0, FIRST_GEN));
		push_op(make_op(FUNC_QUERY, 0, '0));
		push_op(make_op(FUNC_QUERY, 5, FIRST_GEN));
		push_op(make_op(FUNC_HANDLE_AT, 2, '0));
		push_op(make_op(FUNC_HANDLE_AT, SLOT_COUNT - 1, '0));
		push_op(make_op(FUNC_DESTROY, 1, FIRST_GEN));
		push_op(make_op(FUNC_DESTROY, 1, FIRST_GEN));
		push_op(make_op(FUNC_QUERY, 1, 2));
		push_op(make_op(FUNC_HANDLE_AT, 1, LAST_GEN));
		push_op(make_op(FUNC_CREATE, 0, '0));
		push_op(make_op(FUNC_DESTROY, 1, FIRST_GEN));
		push_op(make_op(FUNC_QUERY, 1, LAST_GEN));
		push_op(make_op(FUNC_DESTROY, 0, FIRST_GEN));
		push_op(make_op(FUNC_DESTROY, 2, FIRST_GEN));
		push_op(make_op(FUNC_CREATE, 0, '0));
		push_op(make_op(FUNC_CREATE, 0, '0));
		push_op(make_op(FUNC_CREATE, 0, '0));
		push_op(make_op(FUNC_DESTROY, SLOT_COUNT - 1, LAST_GEN));
		push_op(make_op(FUNC_HANDLE_AT, 0, '0));
		push_op(make_op(FUNC_QUERY, 1, 2));
		wait_accepted();

		issue_random(150, 35, 1'b0);
		issue_random(120, 85, 1'b1);
		issue_random(40, 60, 1'b0);
		issue_random(70, 15, 1'b0);
		issue_random(50, 60, 1'b0);

		wait_accepted();
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
